@@ design/bitmap_block_allocator_defines.svh @@
// Assertion macros for the bitmap block allocator checker.
// No dependencies; included by the checker file.
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/bba_pkg.sv @@
// Shared constants and codes of the bitmap block allocator.
// No dependencies; used by the allocator top level, the checker and the bench.
`default_nettype none
package bba_pkg;
  localparam int DEF_NUM_BLOCKS = 1024;
  localparam int WORD_BITS = 32;
  localparam int CHUNK_BITS = 8;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;
  localparam logic [1:0] KIND_RESERVE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_SHIFT = 1'b1;

  localparam logic [4:0] SHIFT_RESET = 5'd12;
endpackage
`default_nettype wire

@@ design/bba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used by the bitmap block allocator for its used map.
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/bitmap_block_allocator.sv @@
// Bitmap first-fit block allocator: top level with its control sequencer.
// Depends on bba_pkg and bba_ram.
// One transaction is worked at a time. After reset a clearing pass over the map marks every
// block used, and no transaction is accepted until it ends. Allocate scans the used map in the
// RAM one word at a time, eight blocks a cycle while it scans a word, with a wait state before
// each word read, up to the word where the run ends, then reads and writes back each word it
// marks. Free and reserve read and write back each touched word. Refused requests go straight
// to the result. A new transaction is accepted while the previous result waits.
`default_nettype none
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [9:0]  start_block,
  input  wire logic [10:0] block_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [9:0]       found_block,
  output logic [31:0]      found_address
);
  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int BX = AW + 5;
  localparam int PW = (BX > 11 ? BX : 11) + 1;

  localparam logic [2:0] S_CLR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SWAIT = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_RRD = 3'd4;
  localparam logic [2:0] S_RWR = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]    state;
  logic [AW-1:0] word;
  logic [1:0]    chunk;
  logic [10:0]   run;
  logic [10:0]   cnt;
  logic [BX-1:0] first;
  logic [BX-1:0] last;
  logic          setv;
  logic          res_alloc;
  logic [1:0]    res_status;
  logic [PW-1:0] res_s;
  logic [31:0]   base_address;
  logic [4:0]    block_shift;

  logic          we;
  logic [31:0]   wdata;
  logic [31:0]   rdata;

  logic [10:0]   run_v;
  logic          hit;
  logic [PW-1:0] hit_s;
  logic [PW-1:0] pos;
  logic [7:0]    bits;

  logic [PW-1:0] start_x;
  logic [PW-1:0] count_x;
  logic [PW-1:0] end_x;
  logic [PW-1:0] lim_x;
  logic [31:0]   mask;
  logic          is_last_word;

  bba_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (word),
    .wdata (wdata),
    .raddr (word),
    .rdata (rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign is_last_word = (word == AW'(MAP_WORDS - 1));

  always_comb begin
    run_v = run;
    hit = 1'b0;
    hit_s = '0;
    pos = '0;
    bits = rdata[chunk*CHUNK_BITS +: CHUNK_BITS];
    for (int j = 0; j < CHUNK_BITS; j++) begin
      pos = PW'({word, chunk, 3'(j)});
      if (!hit) begin
        if (bits[j] || pos >= PW'(NUM_BLOCKS)) begin
          run_v = '0;
        end else begin
          run_v = run_v + 11'd1;
          if (run_v == cnt) begin
            hit = 1'b1;
            hit_s = pos + PW'(1) - PW'(cnt);
          end
        end
      end
    end
  end

  assign start_x = PW'(start_block);
  assign count_x = PW'(block_count);
  assign end_x = start_x + count_x - PW'(1);
  assign lim_x = PW'(NUM_BLOCKS - 1);

  always_comb begin
    mask = '1;
    if (word == first[BX-1:5]) begin
      mask = mask & ({32{1'b1}} << first[4:0]);
    end
    if (word == last[BX-1:5]) begin
      mask = mask & ({32{1'b1}} >> (~last[4:0]));
    end
    we = 1'b0;
    wdata = '1;
    if (state == S_CLR) begin
      we = 1'b1;
    end else if (state == S_RWR) begin
      we = 1'b1;
      wdata = setv ? (rdata | mask) : (rdata & ~mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      block_shift <= SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE:  base_address <= cfg_data;
        REG_SHIFT: block_shift <= cfg_data[4:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      word <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          word <= word + AW'(1);
          if (is_last_word) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cnt <= block_count;
            res_s <= '0;
            res_alloc <= 1'b0;
            setv <= (kind == KIND_RESERVE);
            first <= BX'(start_x);
            last <= BX'(end_x > lim_x ? lim_x : end_x);
            chunk <= '0;
            run <= '0;
            if (kind == 2'd3 || block_count == 11'd0 || count_x > PW'(NUM_BLOCKS)) begin
              res_status <= ST_BAD;
              state <= S_DONE;
            end else if (kind == KIND_ALLOC) begin
              res_status <= ST_DONE;
              word <= '0;
              state <= S_SWAIT;
            end else if (start_x >= PW'(NUM_BLOCKS)) begin
              res_status <= ST_BAD;
              state <= S_DONE;
            end else begin
              res_status <= (end_x > lim_x) ? ST_BAD : ST_DONE;
              word <= AW'(start_x >> 5);
              state <= S_RRD;
            end
          end
        end
        S_SWAIT: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          run <= run_v;
          chunk <= chunk + 2'd1;
          if (hit) begin
            res_alloc <= 1'b1;
            res_s <= hit_s;
            setv <= 1'b1;
            first <= BX'(hit_s);
            last <= BX'(hit_s + PW'(cnt) - PW'(1));
            word <= AW'(hit_s >> 5);
            state <= S_RRD;
          end else if (chunk == 2'd3) begin
            if (is_last_word) begin
              res_status <= ST_NOFIT;
              state <= S_DONE;
            end else begin
              word <= word + AW'(1);
              state <= S_SWAIT;
            end
          end
        end
        S_RRD: begin
          state <= S_RWR;
        end
        S_RWR: begin
          if (word == last[BX-1:5]) begin
            state <= S_DONE;
          end else begin
            word <= word + AW'(1);
            state <= S_RRD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status <= res_status;
            found_block <= res_alloc ? res_s[9:0] : 10'd0;
            found_address <= res_alloc ? (((32'(res_s)) << block_shift) + base_address)
                                       : 32'd0;
            state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/bba_checker.sv @@
// Port-level checker for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator_defines.svh.
`default_nettype none
`include "bitmap_block_allocator_defines.svh"
module bba_checker import bba_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [9:0]  found_block,
  input wire logic [31:0] found_address
);
  `BBA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `BBA_ASSERT_NOW(a_fail_zero, out_valid && status != ST_DONE,
    found_block == 10'd0 && found_address == 32'd0, "failed result carries data")
  `BBA_ASSERT_NOW(a_status_code, out_valid, status != 2'd3, "unknown status code")
  `BBA_ASSERT_NEXT(a_result_hold, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(found_address), "result changed while stalled")
endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
`default_nettype wire

@@ bench/tb_bitmap_block_allocator.sv @@
// Self-checking bench for the bitmap first-fit block allocator.
// Depends on bba_pkg and the allocator RTL; holds its own model of the used map.
`default_nettype none
module tb_bitmap_block_allocator;
  import bba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = DEF_NUM_BLOCKS;
  localparam int WATCHDOG = 200000;

  logic clk, rst;
  logic cfg_we;
  logic cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] kind;
  logic [9:0] start_block;
  logic [10:0] block_count;
  logic out_valid, out_ready;
  logic [1:0] status;
  logic [9:0] found_block;
  logic [31:0] found_address;

  bitmap_block_allocator dut (.*);

  typedef struct packed {
    logic [1:0]  st;
    logic [9:0]  blk;
    logic [31:0] addr;
  } alloc_result_t;

  typedef struct {
    logic [1:0]  k;
    logic [9:0]  sb;
    logic [10:0] cnt;
    bit          typed;
    logic [1:0]  st;
  } request_row_t;

  logic [NBLK-1:0] used_bits;
  logic [31:0] base_reg;
  logic [4:0] shift_reg;
  alloc_result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit no_idle = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic alloc_result_t predict_request(logic [1:0] k, logic [9:0] sb,
                                                    logic [10:0] cnt);
    alloc_result_t r;
    int run, s, n;
    logic [63:0] a;
    r = '0;
    s = -1;
    run = 0;
    if (k == 2'd3 || cnt == 0 || cnt > NBLK) begin
      r.st = ST_BAD;
    end else if (k == KIND_ALLOC) begin
      for (int i = 0; i < NBLK && s < 0; i++) begin
        if (used_bits[i]) run = 0;
        else begin
          run++;
          if (run == cnt) s = i + 1 - cnt;
        end
      end
      if (s >= 0) begin
        for (int i = 0; i < cnt; i++) used_bits[s+i] = 1'b1;
        a = (64'(s) << shift_reg) + 64'(base_reg);
        r.st = ST_DONE;
        r.blk = s[9:0];
        r.addr = a[31:0];
      end else r.st = ST_NOFIT;
    end else begin
      n = cnt;
      r.st = ST_DONE;
      if (n > NBLK - sb) begin
        n = NBLK - sb;
        r.st = ST_BAD;
      end
      for (int i = 0; i < n; i++) used_bits[sb+i] = (k == KIND_RESERVE);
    end
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BASE) base_reg = val;
    else shift_reg = val[4:0];
    @(posedge clk);
  endtask

  task automatic send_request(logic [1:0] k, logic [9:0] sb, logic [10:0] cnt);
    while (!no_idle && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    start_block <= sb;
    block_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_request(k, sb, cnt));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [1:0] k;
    logic [10:0] cnt;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99) < 45 ? KIND_ALLOC : ($urandom_range(99) < 60 ? KIND_FREE :
          ($urandom_range(99) < 90 ? KIND_RESERVE : 2'd3));
      case ($urandom_range(9))
        0: cnt = 11'($urandom_range(2047));
        1: cnt = 11'($urandom_range(1024, 1000));
        default: cnt = 11'($urandom_range(40, 1));
      endcase
      send_request(k, 10'($urandom_range(1023)), cnt);
    end
  endtask

  // Receiver with random stalls and one long hold-off.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= no_idle || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction waiting");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, status);
          errors++;
        end
        if (found_block !== e.blk) begin
          $error("found_block expected %0d actual %0d", e.blk, found_block);
          errors++;
        end
        if (found_address !== e.addr) begin
          $error("found_address expected %h actual %h", e.addr, found_address);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    request_row_t rows[$];
    alloc_result_t got;
    rows = '{
      '{KIND_ALLOC, 10'd0, 11'd1, 1'b1, ST_NOFIT},
      '{KIND_FREE, 10'd0, 11'd0, 1'b1, ST_BAD},
      '{KIND_ALLOC, 10'd0, 11'd1025, 1'b1, ST_BAD},
      '{2'd3, 10'd5, 11'd4, 1'b1, ST_BAD},
      '{KIND_FREE, 10'd0, 11'd1024, 1'b1, ST_DONE},
      '{KIND_ALLOC, 10'd1023, 11'd1024, 1'b0, 2'd0},
      '{KIND_ALLOC, 10'd0, 11'd1, 1'b1, ST_NOFIT},
      '{KIND_FREE, 10'd1000, 11'd2047, 1'b1, ST_BAD},
      '{KIND_ALLOC, 10'd0, 11'd24, 1'b0, 2'd0},
      '{KIND_RESERVE, 10'd1023, 11'd1, 1'b0, 2'd0},
      '{KIND_FREE, 10'd31, 11'd3, 1'b0, 2'd0},
      '{KIND_ALLOC, 10'd0, 11'd2, 1'b0, 2'd0},
      '{KIND_FREE, 10'd0, 11'd1024, 1'b0, 2'd0},
      '{KIND_ALLOC, 10'd0, 11'd1023, 1'b0, 2'd0},
      '{KIND_ALLOC, 10'd0, 11'd1, 1'b0, 2'd0},
      '{KIND_RESERVE, 10'd512, 11'd600, 1'b1, ST_BAD},
      '{KIND_FREE, 10'd100, 11'd700, 1'b0, 2'd0},
      '{KIND_ALLOC, 10'd0, 11'd500, 1'b0, 2'd0}
    };
    used_bits = '1;
    base_reg = '0;
    shift_reg = SHIFT_RESET;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = '0;
    start_block = '0;
    block_count = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        got = predict_request(rows[i].k, rows[i].sb, rows[i].cnt);
        got.st = rows[i].st;
        got.blk = '0;
        got.addr = '0;
        while (!no_idle && $urandom_range(99) < 16) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= rows[i].k;
        start_block <= rows[i].sb;
        block_count <= rows[i].cnt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(got);
      end else send_request(rows[i].k, rows[i].sb, rows[i].cnt);
    end
    drain();
    write_reg(REG_BASE, 32'hFFFF_FFFF);
    write_reg(REG_SHIFT, 32'd31);
    send_request(KIND_FREE, 10'd0, 11'd1024);
    random_phase(400);
    drain();
    write_reg(REG_BASE, 32'h0);
    write_reg(REG_SHIFT, 32'd0);
    no_idle = 1;
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_phase(400);
    join
    no_idle = 0;
    drain();
    write_reg(REG_BASE, $urandom);
    write_reg(REG_SHIFT, $urandom_range(31));
    random_phase(1200);
    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
